/* design/lmfde_pkg.sv */
// lmfde_pkg: shared constants, types and helpers of the LED matrix drawing engine
// no dependencies; used by every module of the block

package lmfde_pkg;

    // matrix geometry
    localparam int MATRIX_WIDTH  = 64;
    localparam int MATRIX_HEIGHT = 32;

    localparam int ROW_W      = $clog2(MATRIX_HEIGHT);
    localparam int COL_W      = $clog2(MATRIX_WIDTH);
    localparam int DEPTH      = MATRIX_WIDTH * MATRIX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int LINE_IDX_W = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int LINE_DEPTH = 2 ** LINE_IDX_W;
    localparam int PIX_W      = 24;

    // glyph shape
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

    // command codes
    localparam logic [2:0] OP_GLYPH   = 3'd0;
    localparam logic [2:0] OP_ROT_ROW = 3'd1;
    localparam logic [2:0] OP_ROT_COL = 3'd2;
    localparam logic [2:0] OP_FILL    = 3'd3;
    localparam logic [2:0] OP_OUTLINE = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [PIX_W-1:0]      pix_t;
    typedef logic [LINE_IDX_W-1:0] line_idx_t;

    // frame store access of one cycle
    typedef struct packed {
        logic  we;
        addr_t waddr;
        pix_t  wdata;
        logic  re;
        addr_t raddr;
    } frame_req_t;

    // line buffer access of one cycle
    typedef struct packed {
        logic      we;
        line_idx_t waddr;
        pix_t      wdata;
        logic      re;
        line_idx_t raddr;
    } line_req_t;

    // floor modulo of every signed 8-bit shift, indexed by its raw byte
    typedef logic [7:0] rot_tbl_t [256];

    function automatic rot_tbl_t build_rot_tbl(input int len);
        rot_tbl_t tbl;
        int       m;
        m = 0;
        // walk down to -128 mod len
        for (int t = 0; t < 128; t++) begin
            m = (m == 0) ? len - 1 : m - 1;
        end
        // then count up through -128..127
        for (int j = 0; j < 256; j++) begin
            tbl[8'(j + 128)] = 8'(m);
            m = (m == len - 1) ? 0 : m + 1;
        end
        return tbl;
    endfunction

    localparam rot_tbl_t ROW_ROT_TBL = build_rot_tbl(MATRIX_WIDTH);
    localparam rot_tbl_t COL_ROT_TBL = build_rot_tbl(MATRIX_HEIGHT);

    // linear pixel address, row major
    function automatic addr_t pix_addr(input logic [ROW_W-1:0] row,
                                       input logic [COL_W-1:0] col);
        return ADDR_W'(32'(row) * MATRIX_WIDTH + 32'(col));
    endfunction

endpackage

/* design/lmfde_cmd_if.sv */
// lmfde_cmd_if: command channel of the LED matrix drawing engine
// valid/ready handshake with the command fields; no dependencies

interface lmfde_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic [7:0]        first_row;
    logic [7:0]        first_col;
    logic [7:0]        last_row;
    logic [7:0]        last_col;
    logic signed [7:0] shift_amount;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [34:0]       glyph_bits;

    modport source (
        output valid, opcode, first_row, first_col, last_row, last_col,
               shift_amount, red, green, blue, glyph_bits,
        input  ready
    );

    modport sink (
        input  valid, opcode, first_row, first_col, last_row, last_col,
               shift_amount, red, green, blue, glyph_bits,
        output ready
    );
endinterface

/* design/lmfde_rsp_if.sv */
// lmfde_rsp_if: result channel of the LED matrix drawing engine
// valid/ready handshake with the pixel and status fields; no dependencies

interface lmfde_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       status;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue, status,
        input  ready
    );

    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue, status,
        output ready
    );
endinterface

/* design/lmfde_frame_mem.sv */
// lmfde_frame_mem: frame store memory, one write and one registered read per cycle
// sweeps all entries to black after reset; depends on lmfde_pkg

module lmfde_frame_mem (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lmfde_pkg::frame_req_t   req,
    output lmfde_pkg::pix_t         rdata,
    output logic                    busy
);
    import lmfde_pkg::*;

    pix_t  mem [DEPTH];
    pix_t  rdata_reg;
    logic  clr_busy_reg;
    addr_t clr_addr_reg;

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

/* design/lmfde_line_buf.sv */
// lmfde_line_buf: holding buffer for one row or column during a rotation
// one write and one registered read per cycle; depends on lmfde_pkg

module lmfde_line_buf (
    input  logic                  clk,
    input  lmfde_pkg::line_req_t  req,
    output lmfde_pkg::pix_t       rdata
);
    import lmfde_pkg::*;

    pix_t mem [LINE_DEPTH];
    pix_t rdata_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/lmfde_ctrl.sv */
// lmfde_ctrl: command sequencer, walks frame store pixels one per cycle
// drives frame store and line buffer accesses; depends on lmfde_pkg and channel interfaces

module lmfde_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    lmfde_cmd_if.sink              cmd,
    lmfde_rsp_if.source            rsp,
    input  logic                   store_busy,
    input  lmfde_pkg::pix_t        frame_rdata,
    input  lmfde_pkg::pix_t        line_rdata,
    output lmfde_pkg::frame_req_t  frame_req,
    output lmfde_pkg::line_req_t   line_req
);
    import lmfde_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_GLYPH     = 4'd1;
    localparam logic [3:0] ST_RECT      = 4'd2;
    localparam logic [3:0] ST_ROT_LOAD  = 4'd3;
    localparam logic [3:0] ST_ROT_DRAIN = 4'd4;
    localparam logic [3:0] ST_ROT_STORE = 4'd5;
    localparam logic [3:0] ST_ROT_LAST  = 4'd6;
    localparam logic [3:0] ST_READ      = 4'd7;
    localparam logic [3:0] ST_DONE      = 4'd8;

    localparam logic [8:0] H9        = 9'(MATRIX_HEIGHT);
    localparam logic [8:0] W9        = 9'(MATRIX_WIDTH);
    localparam logic [7:0] ROW_MAX   = 8'(MATRIX_HEIGHT - 1);
    localparam logic [7:0] COL_MAX   = 8'(MATRIX_WIDTH - 1);
    localparam line_idx_t  ROW_LAST  = LINE_IDX_W'(MATRIX_WIDTH - 1);
    localparam line_idx_t  COL_LAST  = LINE_IDX_W'(MATRIX_HEIGHT - 1);
    localparam logic [LINE_IDX_W:0] ROW_LEN = (LINE_IDX_W + 1)'(MATRIX_WIDTH);
    localparam logic [LINE_IDX_W:0] COL_LEN = (LINE_IDX_W + 1)'(MATRIX_HEIGHT);

    // control state
    logic [3:0] state_reg, state_next;
    logic       ld_valid_reg, ld_valid_next;
    logic       st_valid_reg, st_valid_next;
    logic       out_valid_reg, out_valid_next;

    // command and walk registers
    logic [2:0]            op_reg, op_next;
    logic [7:0]            r0_reg, r0_next, c0_reg, c0_next;
    logic [7:0]            r1_reg, r1_next, c1_reg, c1_next;
    logic [7:0]            rl_reg, rl_next, cl_reg, cl_next;
    pix_t                  rgb_reg, rgb_next;
    logic [GLYPH_BITS-1:0] glyph_reg, glyph_next;
    line_idx_t             k_reg, k_next;
    logic                  status_reg, status_next;
    logic [2:0]            gr_reg, gr_next, gc_reg, gc_next;
    logic [7:0]            rr_reg, rr_next, cc_reg, cc_next;
    line_idx_t             idx_reg, idx_next;
    line_idx_t             ld_idx_reg, ld_idx_next;
    line_idx_t             st_idx_reg, st_idx_next;
    pix_t                  out_pix_reg, out_pix_next;
    logic                  out_status_reg, out_status_next;

    logic                  accept;
    logic                  line_is_row;
    line_idx_t             line_last;
    logic [LINE_IDX_W:0]   line_len;
    logic [LINE_IDX_W:0]   src_sum;
    line_idx_t             src_idx;
    logic [8:0]            g_row, g_col;
    logic                  border;

    function automatic addr_t line_addr(input logic is_row, input logic [7:0] r0,
                                        input logic [7:0] c0, input line_idx_t i);
        addr_t a;
        if (is_row)
        begin
            a = pix_addr(r0[ROW_W-1:0], i[COL_W-1:0]);
        end
        else
        begin
            a = pix_addr(i[ROW_W-1:0], c0[COL_W-1:0]);
        end
        return a;
    endfunction

    assign cmd.ready = (state_reg == ST_IDLE) && !store_busy;
    assign accept    = cmd.valid && cmd.ready;

    // rotation source index, one compare and subtract
    assign line_is_row = (op_reg == OP_ROT_ROW);
    assign line_last   = line_is_row ? ROW_LAST : COL_LAST;
    assign line_len    = line_is_row ? ROW_LEN : COL_LEN;
    assign src_sum     = {1'b0, idx_reg} + {1'b0, k_reg};
    assign src_idx     = (src_sum >= line_len) ? LINE_IDX_W'(src_sum - line_len)
                                               : LINE_IDX_W'(src_sum);

    // glyph target pixel and outline membership
    assign g_row  = {1'b0, r0_reg} + {6'd0, gr_reg};
    assign g_col  = {1'b0, c0_reg} + {6'd0, gc_reg};
    assign border = (rr_reg == r0_reg) || (rr_reg == r1_reg) ||
                    (cc_reg == c0_reg) || (cc_reg == c1_reg);

    // memory accesses
    always_comb
    begin
        frame_req       = '0;
        frame_req.wdata = rgb_reg;
        line_req        = '0;
        if (st_valid_reg)
        begin
            frame_req.we    = 1'b1;
            frame_req.waddr = line_addr(line_is_row, r0_reg, c0_reg, st_idx_reg);
            frame_req.wdata = line_rdata;
        end
        else if (state_reg == ST_GLYPH)
        begin
            frame_req.we    = glyph_reg[0] && (g_row < H9) && (g_col < W9);
            frame_req.waddr = pix_addr(g_row[ROW_W-1:0], g_col[COL_W-1:0]);
        end
        else if (state_reg == ST_RECT)
        begin
            frame_req.we    = (op_reg == OP_FILL) || border;
            frame_req.waddr = pix_addr(rr_reg[ROW_W-1:0], cc_reg[COL_W-1:0]);
        end
        if (state_reg == ST_ROT_LOAD)
        begin
            frame_req.re    = 1'b1;
            frame_req.raddr = line_addr(line_is_row, r0_reg, c0_reg, idx_reg);
        end
        else if (state_reg == ST_READ)
        begin
            frame_req.re    = 1'b1;
            frame_req.raddr = pix_addr(r0_reg[ROW_W-1:0], c0_reg[COL_W-1:0]);
        end
        line_req.we    = ld_valid_reg;
        line_req.waddr = ld_idx_reg;
        line_req.wdata = frame_rdata;
        line_req.re    = (state_reg == ST_ROT_STORE);
        line_req.raddr = src_idx;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        r0_next         = r0_reg;
        c0_next         = c0_reg;
        r1_next         = r1_reg;
        c1_next         = c1_reg;
        rl_next         = rl_reg;
        cl_next         = cl_reg;
        rgb_next        = rgb_reg;
        glyph_next      = glyph_reg;
        k_next          = k_reg;
        status_next     = status_reg;
        gr_next         = gr_reg;
        gc_next         = gc_reg;
        rr_next         = rr_reg;
        cc_next         = cc_reg;
        idx_next        = idx_reg;
        ld_valid_next   = (state_reg == ST_ROT_LOAD);
        ld_idx_next     = idx_reg;
        st_valid_next   = (state_reg == ST_ROT_STORE);
        st_idx_next     = idx_reg;
        out_valid_next  = out_valid_reg;
        out_pix_next    = out_pix_reg;
        out_status_next = out_status_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd.opcode;
                    r0_next     = cmd.first_row;
                    c0_next     = cmd.first_col;
                    r1_next     = cmd.last_row;
                    c1_next     = cmd.last_col;
                    rl_next     = (cmd.last_row > ROW_MAX) ? ROW_MAX : cmd.last_row;
                    cl_next     = (cmd.last_col > COL_MAX) ? COL_MAX : cmd.last_col;
                    rgb_next    = {cmd.red, cmd.green, cmd.blue};
                    glyph_next  = cmd.glyph_bits;
                    status_next = 1'b0;
                    gr_next     = '0;
                    gc_next     = '0;
                    rr_next     = cmd.first_row;
                    cc_next     = cmd.first_col;
                    idx_next    = '0;
                    state_next  = ST_DONE;
                    // table is indexed by the raw shift byte
                    if (cmd.opcode == OP_ROT_ROW)
                    begin
                        k_next = LINE_IDX_W'(ROW_ROT_TBL[$unsigned(cmd.shift_amount)]);
                    end
                    else
                    begin
                        k_next = LINE_IDX_W'(COL_ROT_TBL[$unsigned(cmd.shift_amount)]);
                    end
                    priority case (cmd.opcode)
                        OP_GLYPH:
                        begin
                            state_next = ST_GLYPH;
                        end
                        OP_ROT_ROW:
                        begin
                            if ({1'b0, cmd.first_row} >= H9)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ROT_LOAD;
                            end
                        end
                        OP_ROT_COL:
                        begin
                            if ({1'b0, cmd.first_col} >= W9)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ROT_LOAD;
                            end
                        end
                        OP_FILL, OP_OUTLINE:
                        begin
                            if (({1'b0, cmd.first_row} < H9) &&
                                ({1'b0, cmd.first_col} < W9) &&
                                (cmd.first_row <= cmd.last_row) &&
                                (cmd.first_col <= cmd.last_col))
                            begin
                                state_next = ST_RECT;
                            end
                        end
                        OP_READ:
                        begin
                            if (({1'b0, cmd.first_row} >= H9) ||
                                ({1'b0, cmd.first_col} >= W9))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_GLYPH:
            begin
                glyph_next = glyph_reg >> 1;
                if (gr_reg == 3'(GLYPH_ROWS - 1))
                begin
                    gr_next = '0;
                    gc_next = gc_reg + 3'd1;
                    if (gc_reg == 3'(GLYPH_COLS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    gr_next = gr_reg + 3'd1;
                end
            end
            ST_RECT:
            begin
                if (cc_reg == cl_reg)
                begin
                    cc_next = c0_reg;
                    rr_next = rr_reg + 8'd1;
                    if (rr_reg == rl_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cc_next = cc_reg + 8'd1;
                end
            end
            ST_ROT_LOAD:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == line_last)
                begin
                    state_next = ST_ROT_DRAIN;
                end
            end
            ST_ROT_DRAIN:
            begin
                idx_next   = '0;
                state_next = ST_ROT_STORE;
            end
            ST_ROT_STORE:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == line_last)
                begin
                    state_next = ST_ROT_LAST;
                end
            end
            ST_ROT_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_pix_next    = ((op_reg == OP_READ) && !status_reg) ? frame_rdata
                                                                            : '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ld_valid_reg  <= 1'b0;
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ld_valid_reg  <= ld_valid_next;
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        r0_reg         <= r0_next;
        c0_reg         <= c0_next;
        r1_reg         <= r1_next;
        c1_reg         <= c1_next;
        rl_reg         <= rl_next;
        cl_reg         <= cl_next;
        rgb_reg        <= rgb_next;
        glyph_reg      <= glyph_next;
        k_reg          <= k_next;
        status_reg     <= status_next;
        gr_reg         <= gr_next;
        gc_reg         <= gc_next;
        rr_reg         <= rr_next;
        cc_reg         <= cc_next;
        idx_reg        <= idx_next;
        ld_idx_reg     <= ld_idx_next;
        st_idx_reg     <= st_idx_next;
        out_pix_reg    <= out_pix_next;
        out_status_reg <= out_status_next;
    end

    // result channel
    assign rsp.valid       = out_valid_reg;
    assign rsp.pixel_red   = out_pix_reg[23:16];
    assign rsp.pixel_green = out_pix_reg[15:8];
    assign rsp.pixel_blue  = out_pix_reg[7:0];
    assign rsp.status      = out_status_reg;

`ifndef SYNTH
    // every frame write lands inside the matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_req.we |-> ({1'b0, frame_req.waddr} < (ADDR_W + 1)'(DEPTH)))
        else $error("frame write outside the matrix");

    // an accepted transaction always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("command accepted without starting");

    // line load and line store phases never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ld_valid_reg && st_valid_reg))
        else $error("rotation load and store overlap");

    // an error result carries a black pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg) |-> (out_pix_reg == '0))
        else $error("error result with nonzero pixel");
`endif

endmodule

/* design/led_matrix_frame_drawing_engine.sv */
// led_matrix_frame_drawing_engine: top level of the LED matrix drawing engine
// depends on lmfde_pkg, lmfde_cmd_if, lmfde_rsp_if, lmfde_frame_mem, lmfde_line_buf, lmfde_ctrl

// Keeps a MATRIX_HEIGHT x MATRIX_WIDTH RGB frame store (24 bits a pixel) in one
// synchronous memory and runs one drawing command per cmd transaction, giving one
// rsp transaction per command. After reset the store is swept to black one pixel
// per cycle (MATRIX_WIDTH * MATRIX_HEIGHT pixels, 2048 at 64 x 32) and cmd.ready
// stays low until the sweep ends. Commands walk the pixels one per cycle through
// the single memory port pair; a rotation copies the line to a line buffer and
// then writes it back rotated. Commands run one at a time; a finished result
// waits in the output register while the next command is taken.

module led_matrix_frame_drawing_engine (
    input  logic         clk,
    input  logic         rst_n,
    lmfde_cmd_if.sink    cmd,
    lmfde_rsp_if.source  rsp
);
    import lmfde_pkg::*;

    frame_req_t frame_req;
    line_req_t  line_req;
    pix_t       frame_rdata;
    pix_t       line_rdata;
    logic       store_busy;

    // frame store
    lmfde_frame_mem u_frame_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (frame_req),
        .rdata (frame_rdata),
        .busy  (store_busy)
    );

    // rotation line buffer
    lmfde_line_buf u_line_buf (
        .clk   (clk),
        .req   (line_req),
        .rdata (line_rdata)
    );

    // command sequencer
    lmfde_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .store_busy  (store_busy),
        .frame_rdata (frame_rdata),
        .line_rdata  (line_rdata),
        .frame_req   (frame_req),
        .line_req    (line_req)
    );

endmodule

/* tb/lmfde_tb_pkg.sv */
// lmfde_tb_pkg: frame store predictor and result scoreboard for the drawing engine bench
// depends on lmfde_pkg

package lmfde_tb_pkg;
    import lmfde_pkg::*;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [7:0]        first_row;
        logic [7:0]        first_col;
        logic [7:0]        last_row;
        logic [7:0]        last_col;
        logic signed [7:0] shift_amount;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [34:0]       glyph_bits;
    } draw_cmd_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       status;
    } pixel_rsp_t;

    class frame_scoreboard;
        logic [23:0] frame [MATRIX_HEIGHT][MATRIX_WIDTH];
        pixel_rsp_t  pending_rsp [$];
        int          mismatch_count;

        function new();
            foreach (frame[r, c]) frame[r][c] = '0;
            mismatch_count = 0;
        endfunction

        function void paint(int row, int col, logic [23:0] rgb);
            if (row < MATRIX_HEIGHT && col < MATRIX_WIDTH)
                frame[row][col] = rgb;
        endfunction

        // apply one accepted command to the frame copy and queue its result
        function void note_command(draw_cmd_t cmd);
            logic [23:0] rgb;
            logic [23:0] line [256];
            pixel_rsp_t  rsp;
            int          k;
            rgb = {cmd.red, cmd.green, cmd.blue};
            rsp = '0;
            case (cmd.opcode)
                OP_GLYPH:
                    for (int c = 0; c < GLYPH_COLS; c++)
                        for (int r = 0; r < GLYPH_ROWS; r++)
                            if (cmd.glyph_bits[c * GLYPH_ROWS + r])
                                paint(cmd.first_row + r, cmd.first_col + c, rgb);
                OP_ROT_ROW:
                    if (cmd.first_row >= MATRIX_HEIGHT) rsp.status = 1'b1;
                    else
                    begin
                        k = int'(cmd.shift_amount) % MATRIX_WIDTH;
                        if (k < 0) k += MATRIX_WIDTH;
                        for (int i = 0; i < MATRIX_WIDTH; i++) line[i] = frame[cmd.first_row][i];
                        for (int i = 0; i < MATRIX_WIDTH; i++)
                            frame[cmd.first_row][i] = line[(i + k) % MATRIX_WIDTH];
                    end
                OP_ROT_COL:
                    if (cmd.first_col >= MATRIX_WIDTH) rsp.status = 1'b1;
                    else
                    begin
                        k = int'(cmd.shift_amount) % MATRIX_HEIGHT;
                        if (k < 0) k += MATRIX_HEIGHT;
                        for (int i = 0; i < MATRIX_HEIGHT; i++) line[i] = frame[i][cmd.first_col];
                        for (int i = 0; i < MATRIX_HEIGHT; i++)
                            frame[i][cmd.first_col] = line[(i + k) % MATRIX_HEIGHT];
                    end
                OP_FILL, OP_OUTLINE:
                    for (int r = cmd.first_row; r <= cmd.last_row; r++)
                        for (int c = cmd.first_col; c <= cmd.last_col; c++)
                            if (cmd.opcode == OP_FILL || r == cmd.first_row
                                || r == cmd.last_row || c == cmd.first_col
                                || c == cmd.last_col)
                                paint(r, c, rgb);
                OP_READ:
                    if (cmd.first_row >= MATRIX_HEIGHT || cmd.first_col >= MATRIX_WIDTH)
                        rsp.status = 1'b1;
                    else
                        {rsp.pixel_red, rsp.pixel_green, rsp.pixel_blue} =
                            frame[cmd.first_row][cmd.first_col];
                default: ;
            endcase
            pending_rsp.push_back(rsp);
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            mismatch_count++;
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(pixel_rsp_t got);
            pixel_rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                report("result with nothing expected");
                return;
            end
            want = pending_rsp.pop_front();
            if (got.pixel_red !== want.pixel_red)
                report($sformatf("pixel_red %0h want %0h", got.pixel_red, want.pixel_red));
            if (got.pixel_green !== want.pixel_green)
                report($sformatf("pixel_green %0h want %0h", got.pixel_green, want.pixel_green));
            if (got.pixel_blue !== want.pixel_blue)
                report($sformatf("pixel_blue %0h want %0h", got.pixel_blue, want.pixel_blue));
            if (got.status !== want.status)
                report($sformatf("status %0b want %0b", got.status, want.status));
        endfunction
    endclass
endpackage

/* tb/led_matrix_frame_drawing_engine_tb.sv */
// led_matrix_frame_drawing_engine_tb: random and directed drawing commands with checking
// depends on lmfde_pkg, lmfde_cmd_if, lmfde_rsp_if, lmfde_tb_pkg and the engine

module led_matrix_frame_drawing_engine_tb;
    import lmfde_pkg::*;
    import lmfde_tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   long_hold = 1'b0;

    lmfde_cmd_if cmd ();
    lmfde_rsp_if rsp ();

    frame_scoreboard sb = new();

    led_matrix_frame_drawing_engine i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.source),
        .rsp   (rsp.sink)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        cmd.valid = 1'b0;
        {cmd.opcode, cmd.first_row, cmd.first_col, cmd.last_row, cmd.last_col} = '0;
        {cmd.shift_amount, cmd.red, cmd.green, cmd.blue, cmd.glyph_bits} = '0;
        rsp.ready = 1'b0;
    end

    // coordinate mostly near the matrix, sometimes anywhere
    function automatic logic [7:0] pick_coord(int lim);
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(0, lim + 4));
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        c = $bits(draw_cmd_t)'({$urandom, $urandom, $urandom, $urandom});
        c.opcode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
        if (c.opcode == OP_READ) c.opcode = ($urandom_range(0, 1)) ? OP_READ : c.opcode;
        c.first_row = pick_coord(MATRIX_HEIGHT);
        c.first_col = pick_coord(MATRIX_WIDTH);
        // keep most rectangles small so the run stays short
        c.last_row = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                     : 8'(c.first_row + $urandom_range(0, 6) - 1);
        c.last_col = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                     : 8'(c.first_col + $urandom_range(0, 8) - 1);
        return c;
    endfunction

    // present one command and wait for its transaction
    // valid stays high after the transaction until the next call or a pause
    task automatic send_cmd(draw_cmd_t c);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.opcode       <= c.opcode;
        cmd.first_row    <= c.first_row;
        cmd.first_col    <= c.first_col;
        cmd.last_row     <= c.last_row;
        cmd.last_col     <= c.last_col;
        cmd.shift_amount <= c.shift_amount;
        cmd.red          <= c.red;
        cmd.green        <= c.green;
        cmd.blue         <= c.blue;
        cmd.glyph_bits   <= c.glyph_bits;
        do @(posedge clk); while (!(cmd.valid && cmd.ready));
        sb.note_command(c);
    endtask

    task automatic send_fields(logic [2:0] op, logic [7:0] r0, logic [7:0] c0,
                               logic [7:0] r1, logic [7:0] c1, logic [7:0] sh,
                               logic [23:0] rgb, logic [34:0] g);
        draw_cmd_t c;
        c = '{op, r0, c0, r1, c1, sh, rgb[23:16], rgb[15:8], rgb[7:0], g};
        send_cmd(c);
    endtask

    // result side: random stalls, one long hold on request
    initial
    begin
        pixel_rsp_t got;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.pixel_red, rsp.pixel_green, rsp.pixel_blue, rsp.status};
                sb.check_result(got);
            end
            if (long_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (600) @(posedge clk);
                long_hold = 1'b0;
                rsp.ready <= 1'b1;
            end
            else if ($urandom_range(0, 3) == 0 && $urandom_range(0, 1))
                rsp.ready <= 1'b0;
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin
        #20000000;
        $display("led_matrix_frame_drawing_engine_tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every command and the corner cases
        send_fields(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_fields(OP_FILL, 0, 0, 31, 63, 0, 24'hFFFFFF, 0);
        send_fields(OP_READ, 31, 63, 0, 0, 0, 0, 0);
        send_fields(OP_FILL, 30, 60, 255, 255, 0, 24'h123456, 0);
        send_fields(OP_OUTLINE, 2, 3, 9, 12, 0, 24'hA5005A, 0);
        send_fields(OP_OUTLINE, 28, 60, 40, 70, 0, 24'h00FF00, 0);
        send_fields(OP_FILL, 5, 5, 4, 9, 0, 24'h010203, 0);
        send_fields(OP_FILL, 5, 9, 7, 5, 0, 24'h010203, 0);
        send_fields(OP_GLYPH, 0, 0, 0, 0, 0, 24'hFF0000, 35'h7_FFFF_FFFF);
        send_fields(OP_GLYPH, 28, 61, 0, 0, 0, 24'h00FF00, 35'h5_5555_5555);
        send_fields(OP_GLYPH, 255, 255, 0, 0, 0, 24'h0000FF, 35'h7_FFFF_FFFF);
        send_fields(OP_ROT_ROW, 0, 0, 0, 0, 8'sd1, 0, 0);
        send_fields(OP_ROT_ROW, 31, 0, 0, 0, 8'h80, 0, 0);
        send_fields(OP_ROT_ROW, 32, 0, 0, 0, 8'h7F, 0, 0);
        send_fields(OP_ROT_COL, 0, 63, 0, 0, 8'hFF, 0, 0);
        send_fields(OP_ROT_COL, 0, 0, 0, 0, 8'h7F, 0, 0);
        send_fields(OP_ROT_COL, 0, 64, 0, 0, 8'h05, 0, 0);
        send_fields(3'd6, 1, 1, 2, 2, 0, 24'hFFFFFF, 0);
        send_fields(3'd7, 1, 1, 2, 2, 0, 24'hFFFFFF, 0);
        send_fields(OP_READ, 32, 0, 0, 0, 0, 0, 0);
        send_fields(OP_READ, 0, 64, 0, 0, 0, 0, 0);
        send_fields(OP_READ, 0, 1, 0, 0, 0, 0, 0);
        send_fields(OP_READ, 2, 3, 0, 0, 0, 0, 0);

        // random part; a long receiver hold and a drained pause midway
        for (int n = 0; n < 800; n++)
        begin
            if (n == 200) long_hold = 1'b1;
            if (n == 500)
            begin
                cmd.valid <= 1'b0;
                while (sb.pending_rsp.size() != 0) @(posedge clk);
            end
            send_cmd(random_cmd());
        end

        cmd.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("led_matrix_frame_drawing_engine_tb OK");
        else
            $display("led_matrix_frame_drawing_engine_tb NOT OK");
        $finish;
    end
endmodule
